[sv/h2n_pkg.sv]
// ----------------------------------------------------------------------------
// h2n_pkg
// Shared types, constants and the height table of the normal map generator.
// ----------------------------------------------------------------------------
package h2n_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int ROW_W      = $clog2(MAX_HEIGHT);
   localparam int DIM_W      = 11;
   localparam int STEEP_W    = 16;
   localparam int COV_W      = 8;
   localparam int CODE_W     = 8;
   localparam int POS_W      = 10;
   localparam int H_W        = 16;
   localparam int G_W        = 24;
   localparam int PROD_W     = 2 * G_W;
   localparam int ROOT_W     = 24;
   localparam int RSP_W      = 48;

   localparam logic [STEEP_W-1:0] STEEP_RESET = 16'd256;

   typedef logic [1:0] csr_addr_type;
   localparam csr_addr_type CSR_IMAGE_WIDTH  = 2'd0;
   localparam csr_addr_type CSR_IMAGE_HEIGHT = 2'd1;
   localparam csr_addr_type CSR_STEEPNESS    = 2'd2;

   localparam longint CUBE_255  = 16581375;
   localparam longint CUBE_HALF = CUBE_255 / 2;

   typedef logic [H_W-1:0] height_lut_type [256];

   // smoothstep height in q0.16, rounded half up, saturated
   function automatic height_lut_type build_height_lut();
      height_lut_type t;
      longint         p;
      longint         h;
      for (int i = 0; i < 256; i++) begin
         p = longint'(i) * longint'(i) * longint'(765 - 2 * i);
         h = (p * 65536 + CUBE_HALF) / CUBE_255;
         if (h > 65535) begin
            h = 65535;
         end
         t[i] = h[H_W-1:0];
      end
      return t;
   endfunction

   localparam height_lut_type HEIGHT_LUT = build_height_lut();

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEL, ST_READ, ST_CAPT, ST_START, ST_CALC, ST_PUSH, ST_DONE
   } st_type;

   typedef enum logic [3:0] {
      U_IDLE, U_MUL_X, U_MUL_Y, U_SQ_X, U_SQ_Y, U_SUM, U_SQRT, U_DIV_LOAD, U_DIV,
      U_DONE
   } unit_st_type;

   typedef struct packed {
      logic [COV_W-1:0] left;
      logic [COV_W-1:0] right;
      logic [COV_W-1:0] up;
      logic [COV_W-1:0] down;
   } nbr_type;

   typedef struct packed {
      logic [CODE_W-1:0] z;
      logic [CODE_W-1:0] y;
      logic [CODE_W-1:0] x;
   } code_type;

endpackage

[sv/height_to_normal_map.sv]
// ----------------------------------------------------------------------------
// height_to_normal_map
// Coverage bytes in raster order to encoded normals by central differences.
// ----------------------------------------------------------------------------
// each normal needs 4 reads of the line store, then the
// shared multiplier, a 24-step square root and three 8-step divides
// output stalls lengthen a beat; req_tready stays low until the beat's last
// normal is registered
// normals lag by one row (on the last row, by one column); synchronous reset clears the
// counters and sets the registers to 1024, 1024 and 256, not the line stores
module height_to_normal_map (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,   // coverage
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [h2n_pkg::RSP_W-1:0]        rsp_tdata,   // normal_x_code, normal_y_code,
                                                         // normal_z_code, pixel_col, pixel_row
   output logic                             rsp_tlast,   // last_in_run
   output logic                             rsp_tuser,   // end_of_frame
   input  logic                             csr_we,
   input  h2n_pkg::csr_addr_type            csr_addr,
   input  logic [h2n_pkg::STEEP_W-1:0]      csr_wdata
);

   localparam int AW = h2n_pkg::COL_W + 1;

   h2n_pkg::st_type st_ff, st_in;

   logic [h2n_pkg::DIM_W-1:0]   width_ff, height_ff;
   logic [h2n_pkg::STEEP_W-1:0] steep_ff;
   logic [h2n_pkg::COL_W-1:0]   col_ff, col_in;
   logic [h2n_pkg::ROW_W-1:0]   row_ff, row_in;
   logic                        sel_ff, sel_in;

   logic [h2n_pkg::COV_W-1:0]   cur_ff, cur_in;
   logic [h2n_pkg::COL_W-1:0]   c_ff, c_in;
   logic [h2n_pkg::ROW_W-1:0]   r_ff, r_in;
   logic                        lcol_ff, lcol_in, lrow_ff, lrow_in;
   logic [2:0]                  mask_ff, mask_in;
   logic [1:0]                  eidx_ff, eidx_in, opk_ff, opk_in;
   h2n_pkg::nbr_type            nbr_ff, nbr_in;

   logic [h2n_pkg::COV_W-1:0]   mem [2 * h2n_pkg::MAX_WIDTH];
   logic [h2n_pkg::COV_W-1:0]   rd_data_ff;
   logic                        mem_we;
   logic [AW-1:0]               raddr, waddr;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [h2n_pkg::RSP_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                        rsp_last_ff, rsp_last_in, rsp_eof_ff, rsp_eof_in;

   logic [h2n_pkg::DIM_W-1:0]   w_eff, h_eff;
   logic [h2n_pkg::COL_W-1:0]   c_sat, cl, cr, cm2, cx;
   logic [h2n_pkg::ROW_W-1:0]   r_sat;
   logic                        rd_newer, rd_cur;
   logic [h2n_pkg::COL_W-1:0]   rd_addr;
   logic                        unit_start, unit_done, out_load, e_last;
   h2n_pkg::code_type           codes;
   logic [h2n_pkg::POS_W-1:0]   pcol, prow;

   h2n_normal_unit u_unit (
      .clock (clock),
      .reset (reset),
      .start (unit_start),
      .nbr   (nbr_ff),
      .steep (steep_ff),
      .done  (unit_done),
      .codes (codes)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= h2n_pkg::DIM_W'(h2n_pkg::MAX_WIDTH);
         height_ff <= h2n_pkg::DIM_W'(h2n_pkg::MAX_HEIGHT);
         steep_ff  <= h2n_pkg::STEEP_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            h2n_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[h2n_pkg::DIM_W-1:0];
            h2n_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[h2n_pkg::DIM_W-1:0];
            h2n_pkg::CSR_STEEPNESS:    steep_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= h2n_pkg::ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      c_ff        <= c_in;
      r_ff        <= r_in;
      lcol_ff     <= lcol_in;
      lrow_ff     <= lrow_in;
      mask_ff     <= mask_in;
      eidx_ff     <= eidx_in;
      opk_ff      <= opk_in;
      nbr_ff      <= nbr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      rsp_eof_ff  <= rsp_eof_in;
   end

   // line stores, older row in bank sel_ff
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= cur_ff;
      end
      rd_data_ff <= mem[raddr];
   end

   always_comb begin
      w_eff = (width_ff == '0) ? h2n_pkg::DIM_W'(1) :
              (width_ff > h2n_pkg::DIM_W'(h2n_pkg::MAX_WIDTH)) ?
              h2n_pkg::DIM_W'(h2n_pkg::MAX_WIDTH) : width_ff;
      h_eff = (height_ff == '0) ? h2n_pkg::DIM_W'(1) :
              (height_ff > h2n_pkg::DIM_W'(h2n_pkg::MAX_HEIGHT)) ?
              h2n_pkg::DIM_W'(h2n_pkg::MAX_HEIGHT) : height_ff;
      c_sat = (h2n_pkg::DIM_W'(col_ff) >= w_eff) ? h2n_pkg::COL_W'(w_eff - 1'b1) : col_ff;
      r_sat = (h2n_pkg::DIM_W'(row_ff) >= h_eff) ? h2n_pkg::ROW_W'(h_eff - 1'b1) : row_ff;

      cl  = (c_ff == '0) ? '0 : c_ff - 1'b1;
      cr  = lcol_ff ? c_ff : c_ff + 1'b1;
      cm2 = (c_ff >= h2n_pkg::COL_W'(2)) ? c_ff - h2n_pkg::COL_W'(2) : '0;
      cx  = c_ff - 1'b1;

      // operand source: bank, address, or the current byte
      rd_newer = 1'b0;
      rd_addr  = c_ff;
      rd_cur   = 1'b0;
      case (eidx_ff)
         2'd0: begin
            case (opk_ff)
               2'd0:    begin rd_newer = 1'b1; rd_addr = cl; end
               2'd1:    begin rd_newer = 1'b1; rd_addr = cr; end
               2'd2:    begin rd_newer = (r_ff < h2n_pkg::ROW_W'(2)); rd_addr = c_ff; end
               default: rd_cur = 1'b1;
            endcase
         end
         2'd1: begin
            case (opk_ff)
               2'd0:    rd_addr = cm2;
               2'd1:    rd_cur = 1'b1;
               2'd2:    begin rd_newer = (r_ff != '0); rd_addr = cx; end
               default: rd_addr = cx;
            endcase
         end
         default: begin
            case (opk_ff)
               2'd0:    begin rd_cur = (c_ff == '0); rd_addr = cl; end
               2'd1:    rd_cur = 1'b1;
               2'd2:    begin rd_cur = (r_ff == '0); rd_newer = 1'b1; rd_addr = c_ff; end
               default: rd_cur = 1'b1;
            endcase
         end
      endcase

      raddr = {rd_newer ^ sel_ff, rd_addr};
      waddr = {sel_ff, c_ff};

      case (eidx_ff)
         2'd0:    begin pcol = h2n_pkg::POS_W'(c_ff); prow = h2n_pkg::POS_W'(r_ff - 1'b1); end
         2'd1:    begin pcol = h2n_pkg::POS_W'(cx);   prow = h2n_pkg::POS_W'(r_ff); end
         default: begin pcol = h2n_pkg::POS_W'(c_ff); prow = h2n_pkg::POS_W'(r_ff); end
      endcase
      case (eidx_ff)
         2'd0:    e_last = !mask_ff[1] && !mask_ff[2];
         2'd1:    e_last = !mask_ff[2];
         default: e_last = 1'b1;
      endcase

      st_in        = st_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      sel_in       = sel_ff;
      cur_in       = cur_ff;
      c_in         = c_ff;
      r_in         = r_ff;
      lcol_in      = lcol_ff;
      lrow_in      = lrow_ff;
      mask_in      = mask_ff;
      eidx_in      = eidx_ff;
      opk_in       = opk_ff;
      nbr_in       = nbr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_eof_in   = rsp_eof_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      mem_we       = 1'b0;
      unit_start   = 1'b0;
      out_load     = 1'b0;

      case (st_ff)
         h2n_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cur_in  = req_tdata;
               c_in    = c_sat;
               r_in    = r_sat;
               lcol_in = (h2n_pkg::DIM_W'(c_sat) == w_eff - 1'b1);
               lrow_in = (h2n_pkg::DIM_W'(r_sat) == h_eff - 1'b1);
               mask_in = {lrow_in && lcol_in, lrow_in && (c_sat != '0), r_sat != '0};
               eidx_in = '0;
               st_in   = h2n_pkg::ST_SEL;
            end
         end
         h2n_pkg::ST_SEL: begin
            opk_in = '0;
            if (mask_ff[eidx_ff]) begin
               st_in = h2n_pkg::ST_READ;
            end else if (eidx_ff == 2'd2) begin
               st_in = h2n_pkg::ST_DONE;
            end else begin
               eidx_in = eidx_ff + 2'd1;
            end
         end
         h2n_pkg::ST_READ: begin
            st_in = h2n_pkg::ST_CAPT;
         end
         h2n_pkg::ST_CAPT: begin
            case (opk_ff)
               2'd0:    nbr_in.left  = rd_cur ? cur_ff : rd_data_ff;
               2'd1:    nbr_in.right = rd_cur ? cur_ff : rd_data_ff;
               2'd2:    nbr_in.up    = rd_cur ? cur_ff : rd_data_ff;
               default: nbr_in.down  = rd_cur ? cur_ff : rd_data_ff;
            endcase
            opk_in = opk_ff + 2'd1;
            st_in  = (opk_ff == 2'd3) ? h2n_pkg::ST_START : h2n_pkg::ST_READ;
         end
         h2n_pkg::ST_START: begin
            unit_start = 1'b1;
            st_in      = h2n_pkg::ST_CALC;
         end
         h2n_pkg::ST_CALC: begin
            if (unit_done) begin
               st_in = h2n_pkg::ST_PUSH;
            end
         end
         h2n_pkg::ST_PUSH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, prow, pcol, codes.z, codes.y, codes.x};
               rsp_last_in  = e_last;
               rsp_eof_in   = (eidx_ff == 2'd2);
               if (eidx_ff == 2'd2) begin
                  st_in = h2n_pkg::ST_DONE;
               end else begin
                  eidx_in = eidx_ff + 2'd1;
                  st_in   = h2n_pkg::ST_SEL;
               end
            end
         end
         h2n_pkg::ST_DONE: begin
            mem_we = 1'b1;
            if (lcol_ff) begin
               col_in = '0;
               row_in = lrow_ff ? '0 : r_ff + 1'b1;
               sel_in = !sel_ff;
            end else begin
               col_in = c_ff + 1'b1;
               row_in = r_ff;
            end
            st_in = h2n_pkg::ST_IDLE;
         end
         default: begin
            st_in = h2n_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_eof_ff;

   a_one_beat_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while a beat is in work");

   a_done_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      unit_done |-> (st_ff == h2n_pkg::ST_CALC))
      else $error("normal unit finished outside the wait state");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending result overwritten");

   a_eof_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tlast)
      else $error("frame end not marked as last of run");

endmodule

[sv/h2n_normal_unit.sv]
// ----------------------------------------------------------------------------
// h2n_normal_unit
// Gradient, length and encoding of one normal on a shared multiplier, a
// bit-serial square root and a restoring divider.
// ----------------------------------------------------------------------------
module h2n_normal_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  h2n_pkg::nbr_type                nbr,
   input  logic [h2n_pkg::STEEP_W-1:0]     steep,
   output logic                            done,
   output h2n_pkg::code_type               codes
);

   h2n_pkg::unit_st_type st_ff, st_in;

   logic                          sgnx_ff, sgnx_in, sgny_ff, sgny_in;
   logic [h2n_pkg::H_W-1:0]       magx_ff, magx_in, magy_ff, magy_in;
   logic [h2n_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [h2n_pkg::G_W-1:0]       gx_ff, gx_in, gy_ff, gy_in;
   logic [h2n_pkg::PROD_W-1:0]    acc_ff, acc_in;
   logic [h2n_pkg::ROOT_W+2:0]    rem_ff, rem_in;
   logic [h2n_pkg::ROOT_W-1:0]    root_ff, root_in;
   logic [4:0]                    cnt_ff, cnt_in;
   logic [33:0]                   drem_ff, drem_in;
   logic [31:0]                   dden_ff, dden_in;
   logic [h2n_pkg::CODE_W-1:0]    q_ff, q_in;
   logic [1:0]                    comp_ff, comp_in;
   h2n_pkg::code_type             codes_ff, codes_in;

   logic [h2n_pkg::G_W-1:0]       mul_a, mul_b;
   logic [h2n_pkg::H_W-1:0]       hl, hr, hu, hd;
   logic signed [h2n_pkg::H_W:0]  diffx, diffy;
   logic [h2n_pkg::H_W:0]         absx, absy;
   logic [h2n_pkg::PROD_W-1:0]    grad_sum;
   logic [h2n_pkg::ROOT_W+2:0]    rem_sh, trial;
   logic signed [h2n_pkg::G_W:0]  vsel;
   logic signed [34:0]            num;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= h2n_pkg::U_IDLE;
      end else begin
         st_ff <= st_in;
      end
      sgnx_ff  <= sgnx_in;
      sgny_ff  <= sgny_in;
      magx_ff  <= magx_in;
      magy_ff  <= magy_in;
      prod_ff  <= prod_in;
      gx_ff    <= gx_in;
      gy_ff    <= gy_in;
      acc_ff   <= acc_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      cnt_ff   <= cnt_in;
      drem_ff  <= drem_in;
      dden_ff  <= dden_in;
      q_ff     <= q_in;
      comp_ff  <= comp_in;
      codes_ff <= codes_in;
   end

   always_comb begin
      hl    = h2n_pkg::HEIGHT_LUT[nbr.left];
      hr    = h2n_pkg::HEIGHT_LUT[nbr.right];
      hu    = h2n_pkg::HEIGHT_LUT[nbr.up];
      hd    = h2n_pkg::HEIGHT_LUT[nbr.down];
      diffx = $signed({1'b0, hr}) - $signed({1'b0, hl});
      diffy = $signed({1'b0, hd}) - $signed({1'b0, hu});
      absx  = diffx[h2n_pkg::H_W] ? 17'(-diffx) : 17'(diffx);
      absy  = diffy[h2n_pkg::H_W] ? 17'(-diffy) : 17'(diffy);

      grad_sum = prod_ff + 48'd256;
      rem_sh   = {rem_ff[h2n_pkg::ROOT_W:0], acc_ff[h2n_pkg::PROD_W-1 -: 2]};
      trial    = {1'b0, root_ff, 2'b01};

      case (comp_ff)
         2'd0:    vsel = sgnx_ff ? -$signed({1'b0, gx_ff}) : $signed({1'b0, gx_ff});
         2'd1:    vsel = sgny_ff ? -$signed({1'b0, gy_ff}) : $signed({1'b0, gy_ff});
         default: vsel = 25'sd65536;
      endcase
      // 256*len + 255*v
      num = $signed({3'b000, root_ff, 8'h00}) + $signed({{2{vsel[h2n_pkg::G_W]}}, vsel, 8'h00})
            - 35'(vsel);

      st_in    = st_ff;
      sgnx_in  = sgnx_ff;
      sgny_in  = sgny_ff;
      magx_in  = magx_ff;
      magy_in  = magy_ff;
      gx_in    = gx_ff;
      gy_in    = gy_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      drem_in  = drem_ff;
      dden_in  = dden_ff;
      q_in     = q_ff;
      comp_in  = comp_ff;
      codes_in = codes_ff;
      mul_a    = '0;
      mul_b    = '0;
      done     = 1'b0;

      case (st_ff)
         h2n_pkg::U_IDLE: begin
            if (start) begin
               // the normal points against the gradient
               sgnx_in = !diffx[h2n_pkg::H_W] && (diffx != '0);
               sgny_in = !diffy[h2n_pkg::H_W] && (diffy != '0);
               magx_in = absx[h2n_pkg::H_W-1:0];
               magy_in = absy[h2n_pkg::H_W-1:0];
               st_in   = h2n_pkg::U_MUL_X;
            end
         end
         h2n_pkg::U_MUL_X: begin
            mul_a = h2n_pkg::G_W'(magx_ff);
            mul_b = h2n_pkg::G_W'(steep);
            st_in = h2n_pkg::U_MUL_Y;
         end
         h2n_pkg::U_MUL_Y: begin
            mul_a = h2n_pkg::G_W'(magy_ff);
            mul_b = h2n_pkg::G_W'(steep);
            gx_in = grad_sum[h2n_pkg::G_W+8:9];
            st_in = h2n_pkg::U_SQ_X;
         end
         h2n_pkg::U_SQ_X: begin
            mul_a = gx_ff;
            mul_b = gx_ff;
            gy_in = grad_sum[h2n_pkg::G_W+8:9];
            st_in = h2n_pkg::U_SQ_Y;
         end
         h2n_pkg::U_SQ_Y: begin
            mul_a  = gy_ff;
            mul_b  = gy_ff;
            acc_in = prod_ff;
            st_in  = h2n_pkg::U_SUM;
         end
         h2n_pkg::U_SUM: begin
            acc_in  = acc_ff + prod_ff + 48'h1_0000_0000;
            rem_in  = '0;
            root_in = '0;
            cnt_in  = '0;
            st_in   = h2n_pkg::U_SQRT;
         end
         h2n_pkg::U_SQRT: begin
            acc_in = {acc_ff[h2n_pkg::PROD_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[h2n_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[h2n_pkg::ROOT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(h2n_pkg::ROOT_W - 1)) begin
               comp_in = '0;
               st_in   = h2n_pkg::U_DIV_LOAD;
            end
         end
         h2n_pkg::U_DIV_LOAD: begin
            drem_in = (num > 0) ? num[33:0] : '0;
            dden_in = {root_ff, 8'h00};
            q_in    = '0;
            cnt_in  = '0;
            st_in   = h2n_pkg::U_DIV;
         end
         h2n_pkg::U_DIV: begin
            if (drem_ff >= 34'(dden_ff)) begin
               drem_in = drem_ff - 34'(dden_ff);
               q_in    = {q_ff[h2n_pkg::CODE_W-2:0], 1'b1};
            end else begin
               q_in    = {q_ff[h2n_pkg::CODE_W-2:0], 1'b0};
            end
            dden_in = dden_ff >> 1;
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'(h2n_pkg::CODE_W - 1)) begin
               case (comp_ff)
                  2'd0:    codes_in.x = q_in;
                  2'd1:    codes_in.y = q_in;
                  default: codes_in.z = q_in;
               endcase
               comp_in = comp_ff + 2'd1;
               st_in   = (comp_ff == 2'd2) ? h2n_pkg::U_DONE : h2n_pkg::U_DIV_LOAD;
            end
         end
         h2n_pkg::U_DONE: begin
            done  = 1'b1;
            st_in = h2n_pkg::U_IDLE;
         end
         default: begin
            st_in = h2n_pkg::U_IDLE;
         end
      endcase

      prod_in = mul_a * mul_b;
   end

   assign codes = codes_ff;

endmodule

[verif/tb_height_to_normal_map.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_height_to_normal_map
// Streams coverage frames of many sizes and steepness settings through the
// normal map generator, predicts every normal in a scoreboard class and
// checks each result beat field by field, under random source gaps and sink
// stalls.
// ----------------------------------------------------------------------------
module tb_height_to_normal_map;

   typedef struct packed {
      logic [7:0] nx;
      logic [7:0] ny;
      logic [7:0] nz;
      logic [9:0] col;
      logic [9:0] row;
      logic       last;
      logic       eof;
   } normal_beat_type;

   class normal_scoreboard_type;
      int unsigned     frame_w = 1024;
      int unsigned     frame_h = 1024;
      longint          steep = 256;
      logic [7:0]      prev2_row [h2n_pkg::MAX_WIDTH];
      logic [7:0]      prev1_row [h2n_pkg::MAX_WIDTH];
      int unsigned     col_pos = 0;
      int unsigned     row_pos = 0;
      normal_beat_type pending [$];
      int              errors = 0;
      int              checked = 0;
      int              frames = 0;

      function void set_reg(h2n_pkg::csr_addr_type idx, logic [15:0] val);
         int unsigned v;
         v = val[10:0];
         if (v < 1) v = 1;
         case (idx)
            h2n_pkg::CSR_IMAGE_WIDTH:
               frame_w = (v > h2n_pkg::MAX_WIDTH) ? h2n_pkg::MAX_WIDTH : v;
            h2n_pkg::CSR_IMAGE_HEIGHT:
               frame_h = (v > h2n_pkg::MAX_HEIGHT) ? h2n_pkg::MAX_HEIGHT : v;
            h2n_pkg::CSR_STEEPNESS: steep = val;
            default: ;
         endcase
      endfunction

      function longint smooth_height(logic [7:0] cov);
         longint c;
         longint h;
         c = cov;
         h = (c * c * (765 - 2 * c) * 65536 + 16581375 / 2) / 16581375;
         return (h > 65535) ? 65535 : h;
      endfunction

      function longint slope(logic [7:0] lo, logic [7:0] hi);
         longint d;
         longint m;
         d = (smooth_height(hi) - smooth_height(lo)) * steep;
         m = (d < 0) ? -d : d;
         m = (m + 256) >>> 9;
         return (d < 0) ? -m : m;
      endfunction

      function longint int_sqrt(longint v);
         longint r;
         longint step;
         r = 0;
         step = longint'(1) << 62;
         while (step > v) step = step >>> 2;
         while (step != 0) begin
            if (v >= r + step) begin
               v = v - (r + step);
               r = (r >>> 1) + step;
            end else begin
               r = r >>> 1;
            end
            step = step >>> 2;
         end
         return r;
      endfunction

      function logic [7:0] to_code(longint v, longint len);
         longint num;
         longint q;
         num = 256 * len + 255 * v;
         if (num <= 0) return 8'd0;
         q = num / (2 * len);
         return (q > 255) ? 8'd255 : q[7:0];
      endfunction

      function void add_normal(logic [7:0] l, logic [7:0] r, logic [7:0] u,
                               logic [7:0] d, int unsigned c, int unsigned rw,
                               bit eof);
         normal_beat_type n;
         longint a;
         longint b;
         longint len;
         a = -slope(l, r);
         b = -slope(u, d);
         len = int_sqrt(a * a + b * b + (longint'(1) << 32));
         n.nx = to_code(a, len);
         n.ny = to_code(b, len);
         n.nz = to_code(65536, len);
         n.col = c[9:0];
         n.row = rw[9:0];
         n.last = 1'b0;
         n.eof = eof;
         pending.push_back(n);
      endfunction

      // predicts the normals released by one accepted coverage beat
      function void note_input(logic [7:0] cov);
         int unsigned c;
         int unsigned r;
         int unsigned cl;
         int unsigned cr;
         int unsigned x;
         int          n_prior;
         logic [7:0]  t;
         n_prior = pending.size();
         if (col_pos >= frame_w) col_pos = frame_w - 1;
         if (row_pos >= frame_h) row_pos = frame_h - 1;
         c = col_pos;
         r = row_pos;
         cl = (c > 0) ? c - 1 : 0;
         cr = (c + 1 < frame_w) ? c + 1 : frame_w - 1;
         if (r >= 1)
            add_normal(prev1_row[cl], prev1_row[cr],
                       (r >= 2) ? prev2_row[c] : prev1_row[c], cov, c, r - 1, 0);
         prev2_row[c] = cov;
         if (r == frame_h - 1) begin
            if (c >= 1) begin
               x = c - 1;
               add_normal(prev2_row[(c >= 2) ? c - 2 : 0], cov,
                          (r >= 1) ? prev1_row[x] : prev2_row[x], prev2_row[x], x, r, 0);
            end
            if (c == frame_w - 1)
               add_normal(prev2_row[cl], cov, (r >= 1) ? prev1_row[c] : cov, cov,
                          c, r, 1);
         end
         if (c == frame_w - 1) begin
            for (int i = 0; i < h2n_pkg::MAX_WIDTH; i++) begin
               t = prev2_row[i];
               prev2_row[i] = prev1_row[i];
               prev1_row[i] = t;
            end
            col_pos = 0;
            if (r + 1 >= frame_h) begin
               row_pos = 0;
               frames++;
            end else begin
               row_pos = r + 1;
            end
         end else begin
            col_pos = c + 1;
         end
         if (pending.size() > n_prior) pending[pending.size() - 1].last = 1'b1;
      endfunction

      function void check(normal_beat_type got);
         normal_beat_type e;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected normal beat col %0d row %0d", got.col, got.row);
            return;
         end
         e = pending.pop_front();
         if (got != e) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch exp x%0d y%0d z%0d c%0d r%0d l%0d e%0d",
                        e.nx, e.ny, e.nz, e.col, e.row, e.last, e.eof);
               $display("         got x%0d y%0d z%0d c%0d r%0d l%0d e%0d",
                        got.nx, got.ny, got.nz, got.col, got.row, got.last, got.eof);
            end
         end
      endfunction
   endclass

   localparam int IDLE_LIMIT = 50000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [h2n_pkg::RSP_W-1:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   h2n_pkg::csr_addr_type csr_addr = h2n_pkg::CSR_IMAGE_WIDTH;
   logic [15:0] csr_wdata = '0;

   normal_scoreboard_type sb = new();
   int          burst_left = 0;
   int          idle_cycles = 0;
   int          sent = 0;
   logic [15:0] stall_pattern = 16'hffff;

   always #5 clock = ~clock;

   height_to_normal_map dut (.*);

   // sink stall pattern, reshuffled now and then, sometimes all ready
   always @(posedge clock) begin
      if (!reset) begin
         if ($urandom_range(0, 63) == 0)
            stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
         else
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15]};
         rsp_tready <= stall_pattern[15];
      end
   end

   always @(posedge clock) begin
      normal_beat_type got;
      if (rsp_tvalid && rsp_tready) begin
         got.nx = rsp_tdata[7:0];
         got.ny = rsp_tdata[15:8];
         got.nz = rsp_tdata[23:16];
         got.col = rsp_tdata[33:24];
         got.row = rsp_tdata[43:34];
         got.last = rsp_tlast;
         got.eof = rsp_tuser;
         sb.check(got);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_cov(logic [7:0] cov);
      req_tvalid <= 1'b1;
      req_tdata <= cov;
      do @(posedge clock); while (!req_tready);
      sb.note_input(cov);
      sent++;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   // drain all normals, then let a beat without normals finish
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_reg(h2n_pkg::csr_addr_type idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   task automatic setup(logic [15:0] w, logic [15:0] h, logic [15:0] s);
      drain();
      write_reg(h2n_pkg::CSR_IMAGE_WIDTH, w);
      write_reg(h2n_pkg::CSR_IMAGE_HEIGHT, h);
      write_reg(h2n_pkg::CSR_STEEPNESS, s);
      csr_we <= 1'b0;
   endtask

   function automatic logic [7:0] pick_cov(int mode);
      case (mode)
         0: return 8'($urandom);
         1: return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
         default: return $urandom_range(0, 1) ? 8'($urandom_range(200, 255))
                                              : 8'($urandom_range(0, 60));
      endcase
   endfunction

   task automatic random_frame(int unsigned w, int unsigned h, logic [15:0] s);
      int mode;
      setup(16'(w), 16'(h), s);
      mode = $urandom_range(0, 2);
      repeat (w * h) send_cov(pick_cov(mode));
   endtask

   initial begin
      logic [7:0] seq [] = '{8'd0, 8'd255, 8'd128, 8'd1, 8'd254, 8'd0, 8'd255, 8'd77, 8'd200};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      setup(16'd3, 16'd3, 16'd256);
      foreach (seq[i]) send_cov(seq[i]);
      setup(16'd0, 16'd1, 16'd0);
      send_cov(8'd255);
      setup(16'd2, 16'd2, 16'hffff);
      send_cov(8'd255); send_cov(8'd0); send_cov(8'd0); send_cov(8'd255);
      setup(16'd4, 16'd1, 16'd1);
      send_cov(8'd0); send_cov(8'd255); send_cov(8'd170); send_cov(8'd85);

      while (sent < 280) begin
         random_frame($urandom_range(1, 12), $urandom_range(1, 6),
                      ($urandom_range(0, 4) == 0) ? 16'hffff
                                                  : 16'($urandom_range(0, 2048)));
      end

      drain();
      $display("sent %0d coverage beats in %0d frames, checked %0d normal beats",
               sent, sb.frames, sb.checked);
      $display("frame sizes 1x1 up to 12 wide and 6 tall, steepness 0 to 65535");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d normals missing", sb.errors, sb.pending.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[height_to_normal_map.f]
sv/h2n_pkg.sv
sv/h2n_normal_unit.sv
sv/height_to_normal_map.sv
verif/tb_height_to_normal_map.sv
